### design/assert_macros.svh
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define AFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked at every edge, reset included
`define AFP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/afp_pkg.sv
// shared widths, constants and divider handshake types for the frame pacer
// no dependencies
package afp_pkg;

  localparam int unsigned TimeW     = 40;
  localparam int unsigned IdealW    = 20;
  localparam int unsigned CountW    = 16;
  localparam int unsigned DeltaW    = 11;
  localparam int unsigned IntervalW = 14;
  localparam int unsigned AdaptW    = 15;
  localparam int unsigned WorkW     = 21;
  localparam int unsigned ProdW     = CountW + IdealW;
  localparam int unsigned NumW      = TimeW + 2;
  localparam int unsigned DenW      = IdealW + 1;
  localparam int unsigned QuotW     = DeltaW + 1;

  localparam logic [TimeW-1:0]  ONE_SECOND_US     = TimeW'(1000000);
  localparam logic [ProdW-1:0]  SPAN_ONE_US       = ProdW'(1000000);
  localparam logic [ProdW-1:0]  SPAN_HIGH_US      = ProdW'(1500000);
  localparam logic [ProdW-1:0]  SPAN_MID_US       = ProdW'(1300000);
  localparam logic [WorkW-1:0]  STEP_BIG_US       = WorkW'(2000);
  localparam logic [WorkW-1:0]  STEP_SMALL_US     = WorkW'(1000);
  localparam logic [WorkW-1:0]  ADAPT_CAP_US      = WorkW'(10000);
  localparam logic [AdaptW-1:0] ADAPT_RESET_US    = AdaptW'(16667);
  localparam logic [IdealW-1:0] IDEAL_RESET_US    = IdealW'(33333);
  localparam logic [DeltaW-1:0] DELTA_MAX         = {DeltaW{1'b1}};
  localparam logic [DeltaW-1:0] DELTA_GAP         = DeltaW'(2);
  localparam logic [CountW-1:0] COUNT_MAX         = {CountW{1'b1}};

  typedef struct packed {
    logic              start;
    logic [NumW-1:0]   num;
    logic [DenW-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DeltaW-1:0] quot;
  } div_rsp_t;

endpackage

### design/afp_div.sv
// restoring divider, one quotient bit per cycle, quotient saturated at 2047
// depends on afp_pkg
module afp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  afp_pkg::div_req_t req,
  output afp_pkg::div_rsp_t rsp
);

  logic [afp_pkg::NumW-1:0]  rem_r, rem_nxt;
  logic [afp_pkg::NumW-1:0]  dsr_r, dsr_nxt;
  logic [afp_pkg::QuotW-1:0] quot_r, quot_nxt;
  logic [3:0]                cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [afp_pkg::NumW:0]    trial;

  // one shared subtract and compare per cycle
  assign trial = {1'b0, rem_r} - {1'b0, dsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.num;
      dsr_nxt  = afp_pkg::NumW'(req.den) << afp_pkg::DeltaW;
      quot_nxt = '0;
      cnt_nxt  = 4'(afp_pkg::DeltaW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[afp_pkg::NumW]) begin
        rem_nxt = trial[afp_pkg::NumW-1:0];
      end
      quot_nxt = {quot_r[afp_pkg::QuotW-2:0], ~trial[afp_pkg::NumW]};
      dsr_nxt  = dsr_r >> 1;
      cnt_nxt  = cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  // top quotient bit set means 2048 or more
  assign rsp.quot = quot_r[afp_pkg::QuotW-1] ? afp_pkg::DELTA_MAX
                                              : quot_r[afp_pkg::DeltaW-1:0];

endmodule

### design/afp_mul.sv
// shared 16 x 20 multiplier with registered product
// depends on afp_pkg
module afp_mul (
  input  logic                       clk,
  input  logic [afp_pkg::CountW-1:0] a,
  input  logic [afp_pkg::IdealW-1:0] b,
  output logic [afp_pkg::ProdW-1:0]  p
);

  logic [afp_pkg::ProdW-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= afp_pkg::ProdW'(a) * afp_pkg::ProdW'(b);
  end

  assign p = p_r;

endmodule

### design/adaptive_frame_pacer.sv
// adaptive frame pacer top level: sequencer, time state and output register
// depends on afp_pkg, afp_div, afp_mul
//
// usage:
//   in channel: one 40-bit tick time (us) per word, valid/stall handshake.
//   out channel: frame_delta (whole ideal frames since the frame mark,
//     rounded, saturating at 2047, 2 after a gap over 1 s) and the adaptive
//     wait next_interval_us (0..10000).
//   cfg channel: ideal interval (us), valid/ready, always ready; write it
//     only while no tick is in flight.
//   each tick passes from acceptance to the output register through the
//     window step, the span compare, the shared divider on the rounded
//     frame count, the frame mark and the push, in that order.
//   in_stall is high while a tick is in work, so no new tick is taken
//     until the push. the output register lets a new tick be accepted while
//     the previous result waits; a stalled receiver holds the finished tick
//     in its last step until the output register frees.
//   synchronous reset clears the sequencer, the seed flag and the counters;
//     the ideal interval returns to 33333 and the adaptive interval to 16667.
module adaptive_frame_pacer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [afp_pkg::TimeW-1:0]     in_now_us,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [afp_pkg::DeltaW-1:0]    out_frame_delta,
  output logic [afp_pkg::IntervalW-1:0] out_next_interval_us,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [afp_pkg::IdealW-1:0]    cfg_ideal_interval_us
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADJ  = 3'd1;
  localparam logic [2:0] S_SPAN = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MARK = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;

  logic [2:0]                       state_r, state_nxt;
  logic [afp_pkg::IdealW-1:0]       ideal_r;
  logic [afp_pkg::IdealW-1:0]       prev_ideal_r;
  logic                             seeded_r;
  logic [afp_pkg::TimeW-1:0]        now_r;
  logic [afp_pkg::TimeW-1:0]        window_start_r;
  logic [afp_pkg::TimeW-1:0]        prev_tick_r;
  logic [afp_pkg::TimeW-1:0]        frame_mark_r;
  logic [afp_pkg::AdaptW-1:0]       adaptive_r;
  logic [afp_pkg::CountW-1:0]       tick_count_r;
  logic [afp_pkg::WorkW-1:0]        adapt_work_r;
  logic                             close_r;
  logic                             gap_r;
  logic                             neg_r;
  logic [afp_pkg::DeltaW-1:0]       delta_r;
  logic                             out_valid_r;
  logic [afp_pkg::DeltaW-1:0]       out_delta_r;
  logic [afp_pkg::IntervalW-1:0]    out_interval_r;

  logic                             in_take;
  logic                             out_free;
  logic [afp_pkg::TimeW:0]          win_diff;
  logic [afp_pkg::TimeW:0]          gap_diff;
  logic [afp_pkg::TimeW:0]          mark_diff;
  logic [afp_pkg::IdealW-1:0]       div_w;
  logic [afp_pkg::CountW-1:0]       tick_inc;
  logic [afp_pkg::WorkW-1:0]        adapt_sel;
  logic [afp_pkg::WorkW-1:0]        adapt_adj;
  logic [afp_pkg::WorkW-1:0]        adapt_cap;
  logic [afp_pkg::DeltaW-1:0]       delta_w;
  logic [afp_pkg::CountW-1:0]       mul_a;
  logic [afp_pkg::ProdW-1:0]        mul_p;
  afp_pkg::div_req_t                div_req;
  afp_pkg::div_rsp_t                div_rsp;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // differences are 41-bit two's complement, bit 40 is the sign
  assign win_diff  = {1'b0, now_r} - {1'b0, window_start_r};
  assign gap_diff  = {1'b0, now_r} - {1'b0, prev_tick_r};
  assign mark_diff = {1'b0, now_r} - {1'b0, frame_mark_r};

  assign div_w    = (ideal_r == '0) ? afp_pkg::IdealW'(1) : ideal_r;
  assign tick_inc = (tick_count_r != afp_pkg::COUNT_MAX) ? tick_count_r + 1'b1
                                                         : tick_count_r;
  assign adapt_sel = (prev_ideal_r > ideal_r) ? afp_pkg::WorkW'(ideal_r)
                                              : afp_pkg::WorkW'(adaptive_r);

  // rounded quotient (2*diff + div) / (2*div)
  assign div_req.start = (state_r == S_ADJ);
  assign div_req.num   = {1'b0, mark_diff[afp_pkg::TimeW-1:0], 1'b0}
                       + afp_pkg::NumW'(div_w);
  assign div_req.den   = {div_w, 1'b0};

  afp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign delta_w = gap_r ? afp_pkg::DELTA_GAP : (neg_r ? '0 : div_rsp.quot);
  assign mul_a   = (state_r == S_ADJ) ? tick_inc : afp_pkg::CountW'(delta_w);

  afp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (ideal_r),
    .p   (mul_p)
  );

  // window adjustment from count times ideal interval
  always_comb begin
    adapt_adj = adapt_work_r;
    if (close_r) begin
      if (mul_p > afp_pkg::SPAN_HIGH_US) begin
        adapt_adj = adapt_work_r + afp_pkg::STEP_BIG_US;
      end else if (mul_p > afp_pkg::SPAN_MID_US) begin
        adapt_adj = adapt_work_r + afp_pkg::STEP_SMALL_US;
      end else if (mul_p < afp_pkg::SPAN_ONE_US) begin
        adapt_adj = (adapt_work_r > afp_pkg::STEP_SMALL_US)
                  ? adapt_work_r - afp_pkg::STEP_SMALL_US : '0;
      end
    end
    adapt_cap = (adapt_adj > afp_pkg::ADAPT_CAP_US) ? afp_pkg::ADAPT_CAP_US
                                                    : adapt_adj;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) state_nxt = S_ADJ;
      end
      S_ADJ:  state_nxt = S_SPAN;
      S_SPAN: state_nxt = S_DIV;
      S_DIV: begin
        if (div_rsp.done) state_nxt = S_MARK;
      end
      S_MARK: state_nxt = S_PUSH;
      S_PUSH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ideal_r      <= afp_pkg::IDEAL_RESET_US;
      prev_ideal_r <= afp_pkg::IDEAL_RESET_US;
      seeded_r     <= 1'b0;
      adaptive_r   <= afp_pkg::ADAPT_RESET_US;
      tick_count_r <= '0;
      out_valid_r  <= 1'b0;
      window_start_r <= '0;
      prev_tick_r  <= '0;
      frame_mark_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        ideal_r <= cfg_ideal_interval_us;
      end
      if (in_take && !seeded_r) begin
        seeded_r       <= 1'b1;
        window_start_r <= in_now_us;
        prev_tick_r    <= in_now_us;
        frame_mark_r   <= in_now_us;
      end
      if (state_r == S_ADJ) begin
        prev_ideal_r <= ideal_r;
        tick_count_r <= tick_inc;
      end
      if (state_r == S_SPAN) begin
        adaptive_r <= afp_pkg::AdaptW'(adapt_cap);
        if (close_r) begin
          window_start_r <= now_r;
          tick_count_r   <= '0;
        end
      end
      if (state_r == S_MARK) begin
        prev_tick_r <= now_r;
        if (gap_r) begin
          frame_mark_r <= now_r;
        end else if (!neg_r) begin
          frame_mark_r <= frame_mark_r + afp_pkg::TimeW'(mul_p[30:0]);
        end
      end
      if (state_r == S_PUSH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_take) begin
      now_r <= in_now_us;
    end
    if (state_r == S_ADJ) begin
      adapt_work_r <= adapt_sel;
      close_r <= !win_diff[afp_pkg::TimeW]
              && (win_diff[afp_pkg::TimeW-1:0] > afp_pkg::ONE_SECOND_US);
      gap_r   <= !gap_diff[afp_pkg::TimeW]
              && (gap_diff[afp_pkg::TimeW-1:0] > afp_pkg::ONE_SECOND_US);
      neg_r   <= mark_diff[afp_pkg::TimeW];
    end
    if (state_r == S_DIV && div_rsp.done) begin
      delta_r <= delta_w;
    end
    if (state_r == S_PUSH && out_free) begin
      out_delta_r    <= delta_r;
      out_interval_r <= adaptive_r[afp_pkg::IntervalW-1:0];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_frame_delta      = out_delta_r;
  assign out_next_interval_us = out_interval_r;

endmodule

### design/afp_checker.sv
// port-level checks for the adaptive frame pacer, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module afp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [10:0] out_frame_delta,
  input logic [13:0] out_next_interval_us
);

  // a stalled result word stays offered
  `AFP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result word dropped")

  // the adaptive wait never leaves its cap
  `AFP_ASSERT(a_interval_cap, out_valid |-> out_next_interval_us <= 14'd10000, "wait over cap")

  // an accepted tick keeps the block busy for its work
  `AFP_ASSERT(a_busy_after_take, in_valid && !in_stall |=> in_stall, "not busy after tick")

  // reset empties the output register
  `AFP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result after reset")

endmodule

bind adaptive_frame_pacer afp_checker u_afp_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_frame_delta      (out_frame_delta),
  .out_next_interval_us (out_next_interval_us)
);

### verif/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for adaptive_frame_pacer: paced, gapped and backward tick times
// under several ideal intervals, each result word checked against an in-bench pacing model
// depends on afp_pkg and the adaptive_frame_pacer design files

module testbench;

  localparam longint SecondUs = 1000000;
  localparam longint SpanHighUs = 1500000;
  localparam longint SpanMidUs = 1300000;
  localparam int unsigned StepBigUs = 2000;
  localparam int unsigned StepSmallUs = 1000;
  localparam int unsigned AdaptCapUs = 10000;
  localparam longint unsigned DeltaSat = 2047;
  localparam int unsigned CountSat = 65535;
  localparam int unsigned GapDelta = 2;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned LongHold = 300;
  localparam int unsigned CycleLimit = 1000000;

  typedef struct {
    logic [afp_pkg::DeltaW-1:0]    frame_delta;
    logic [afp_pkg::IntervalW-1:0] next_interval_us;
  } pacer_word_t;

  class pacer_scoreboard;
    logic [afp_pkg::IdealW-1:0] ideal_us;
    bit                         seeded;
    logic [afp_pkg::TimeW-1:0]  window_start_us;
    logic [afp_pkg::TimeW-1:0]  prev_tick_us;
    logic [afp_pkg::TimeW-1:0]  frame_mark_us;
    int unsigned                adapt_us;
    logic [afp_pkg::IdealW-1:0] prev_ideal_us;
    int unsigned                tick_count;
    pacer_word_t                pending_frames[$];
    int unsigned                errors;
    int unsigned                checked;
    int unsigned                windows;
    int unsigned                gaps;
    int unsigned                saturated;

    function new();
      ideal_us = afp_pkg::IDEAL_RESET_US;
      seeded = 1'b0;
      window_start_us = '0;
      prev_tick_us = '0;
      frame_mark_us = '0;
      adapt_us = afp_pkg::ADAPT_RESET_US;
      prev_ideal_us = afp_pkg::IDEAL_RESET_US;
      tick_count = 0;
      errors = 0;
      checked = 0;
      windows = 0;
      gaps = 0;
      saturated = 0;
    endfunction

    function void set_ideal(logic [afp_pkg::IdealW-1:0] value);
      ideal_us = value;
    endfunction

    // works out the result word for one accepted tick
    function void note_tick(logic [afp_pkg::TimeW-1:0] now);
      longint            n;
      longint            diff;
      longint unsigned   span;
      longint unsigned   udiff;
      longint unsigned   div;
      longint unsigned   q;
      int unsigned       adapt;
      pacer_word_t       w;
      n = 64'(now);
      adapt = adapt_us;
      if (!seeded) begin
        seeded = 1'b1;
        window_start_us = now;
        prev_tick_us = now;
        frame_mark_us = now;
      end
      // a lowered ideal interval pulls the adaptive interval down with it
      if (prev_ideal_us != ideal_us) begin
        if (prev_ideal_us > ideal_us) adapt = ideal_us;
        prev_ideal_us = ideal_us;
      end
      if (tick_count < CountSat) tick_count++;
      if (n - longint'(64'(window_start_us)) > SecondUs) begin
        span = 64'(tick_count) * 64'(ideal_us);
        if (span > SpanHighUs) begin
          adapt += StepBigUs;
        end else if (span > SpanMidUs) begin
          adapt += StepSmallUs;
        end else if (span < SecondUs) begin
          adapt = (adapt > StepSmallUs) ? adapt - StepSmallUs : 0;
        end
        window_start_us = now;
        tick_count = 0;
        windows++;
      end
      if (adapt > AdaptCapUs) adapt = AdaptCapUs;
      adapt_us = adapt;
      if (n - longint'(64'(prev_tick_us)) > SecondUs) begin
        w.frame_delta = afp_pkg::DeltaW'(GapDelta);
        frame_mark_us = now;
        gaps++;
      end else begin
        diff = n - longint'(64'(frame_mark_us));
        if (diff < 0) begin
          w.frame_delta = '0;
        end else begin
          udiff = diff;
          div = (ideal_us == '0) ? 64'd1 : 64'(ideal_us);
          // round to nearest, halves up
          q = (2 * udiff + div) / (2 * div);
          if (q > DeltaSat) begin
            q = DeltaSat;
            saturated++;
          end
          w.frame_delta = afp_pkg::DeltaW'(q);
          frame_mark_us = afp_pkg::TimeW'(64'(frame_mark_us) + q * 64'(ideal_us));
        end
      end
      prev_tick_us = now;
      w.next_interval_us = afp_pkg::IntervalW'(adapt);
      pending_frames.push_back(w);
    endfunction

    function void check_result(logic [afp_pkg::DeltaW-1:0] delta,
                               logic [afp_pkg::IntervalW-1:0] interval);
      pacer_word_t w;
      if (pending_frames.size() == 0) begin
        $error("result word with no tick pending: frame_delta %0d next_interval_us %0d",
               delta, interval);
        errors++;
        return;
      end
      w = pending_frames.pop_front();
      checked++;
      if (delta !== w.frame_delta) begin
        $error("frame_delta: expected %0d, got %0d", w.frame_delta, delta);
        errors++;
      end
      if (interval !== w.next_interval_us) begin
        $error("next_interval_us: expected %0d, got %0d", w.next_interval_us, interval);
        errors++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [afp_pkg::TimeW-1:0]     in_now_us = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [afp_pkg::DeltaW-1:0]    out_frame_delta;
  logic [afp_pkg::IntervalW-1:0] out_next_interval_us;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [afp_pkg::IdealW-1:0]    cfg_ideal_interval_us = '0;

  pacer_scoreboard               sb;
  logic [afp_pkg::TimeW-1:0]     tick_time;
  int unsigned                   burst_left = 0;
  int unsigned                   cycle_count = 0;

  always #5 clk = ~clk;

  adaptive_frame_pacer i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_now_us            (in_now_us),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_frame_delta      (out_frame_delta),
    .out_next_interval_us (out_next_interval_us),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_ideal_interval_us(cfg_ideal_interval_us)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_frame_delta, out_next_interval_us);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: runs of different stall patterns, now and then a long hold-off
  initial begin : receiver
    int unsigned mode;
    int unsigned run_len;
    int unsigned hold_at;
    int unsigned k;
    hold_at = 40;
    k = 0;
    @(posedge rst_n);
    forever begin
      if (sb.checked >= hold_at) begin
        repeat (LongHold) @(negedge clk) out_stall <= 1'b1;
        hold_at = sb.checked + $urandom_range(150, 350);
      end
      mode = $urandom_range(0, 3);
      run_len = $urandom_range(5, 60);
      repeat (run_len) begin
        @(negedge clk);
        k++;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= (k % 3 == 0);
        endcase
      end
    end
  end

  // offers one tick word and holds it until taken, then maybe idles
  task automatic send_tick(logic [afp_pkg::TimeW-1:0] t);
    int unsigned gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_now_us <= t;
    do @(posedge clk); while (in_stall);
    sb.note_tick(t);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 24);
      repeat (gap) @(negedge clk) in_valid <= 1'b0;
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_and_settle();
    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending_frames.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_ideal(logic [afp_pkg::IdealW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_ideal_interval_us <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_ideal(value);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  function automatic logic [afp_pkg::TimeW-1:0] next_tick_time(
      logic [afp_pkg::TimeW-1:0] t, logic [afp_pkg::IdealW-1:0] ideal,
      int unsigned pace_pct, bit steady);
    longint unsigned base;
    longint unsigned step_us;
    int unsigned     pick;
    if (ideal == '0) base = $urandom_range(0, 5000);
    else base = (64'(ideal) * pace_pct * $urandom_range(97, 103)) / 10000;
    pick = steady ? 0 : $urandom_range(1, 6);
    case (pick)
      1: step_us = SecondUs + 1 + $urandom_range(0, 2000000);
      2: step_us = 0;
      3: return t - $urandom_range(1, 50000);
      4: step_us = $urandom_range(400000, 1000000);
      5: step_us = $urandom;
      default: step_us = base;
    endcase
    return afp_pkg::TimeW'(64'(t) + step_us);
  endfunction

  // mostly steady runs at one pace, broken up by short irregular runs
  task automatic run_phase(int unsigned items);
    int unsigned left_in_run;
    int unsigned pace_pct;
    bit          steady;
    left_in_run = 0;
    pace_pct = 100;
    steady = 1'b1;
    repeat (items) begin
      if (left_in_run == 0) begin
        steady = ($urandom_range(0, 3) != 0);
        left_in_run = steady ? $urandom_range(20, 80) : $urandom_range(1, 8);
        case ($urandom_range(0, 7))
          0: pace_pct = 50;
          1: pace_pct = 62;
          2: pace_pct = 70;
          3: pace_pct = 74;
          4: pace_pct = 80;
          5: pace_pct = 90;
          6: pace_pct = 105;
          default: pace_pct = 140;
        endcase
      end
      left_in_run--;
      tick_time = next_tick_time(tick_time, sb.ideal_us, pace_pct, steady);
      send_tick(tick_time);
    end
  endtask

  initial begin : stimulus
    logic [afp_pkg::IdealW-1:0] ideal_plan[$];
    int unsigned                phases;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // seeding, rounding just below and at the half, window and gap boundaries,
    // then a step backwards
    send_tick(40'd0);
    send_tick(40'd16666);
    send_tick(40'd16667);
    send_tick(40'd33333);
    send_tick(40'd1033333);
    send_tick(40'd2033333);
    send_tick(40'd2033334);
    send_tick(40'd3033335);
    send_tick(40'd3032835);

    tick_time = {2'b01, 6'($urandom), 32'($urandom)};
    run_phase(100);
    phases = 1;

    ideal_plan = '{20'd1000, 20'd1000000, 20'd0, 20'hFFFFF, 20'd250};
    ideal_plan.push_back(afp_pkg::IdealW'($urandom_range(5000, 60000)));
    ideal_plan.push_back(afp_pkg::IdealW'($urandom_range(60000, 200000)));
    ideal_plan.push_back(20'd16667);
    ideal_plan.push_back(20'd33333);
    foreach (ideal_plan[p]) begin
      drain_and_settle();
      write_ideal(ideal_plan[p]);
      run_phase(90);
      phases++;
    end

    // top of the time range, then a far step backwards
    send_tick({afp_pkg::TimeW{1'b1}} - 40'd20);
    send_tick({afp_pkg::TimeW{1'b1}});
    send_tick(40'd5);

    drain_and_settle();
    repeat (40) @(posedge clk);
    $display("checked %0d result words under %0d ideal intervals", sb.checked, phases);
    $display("%0d windows closed, %0d gap ticks, %0d saturated frame counts",
             sb.windows, sb.gaps, sb.saturated);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
